// ----- src/silu_pkg.sv -----
// ============================================================================
// silu_pkg: shared types, constants and the sigmoid table
// Widths, pipeline depth, the piecewise-linear sigmoid table (Q1.12) and the
// saturation helper used by the SiLU activation unit.
// ============================================================================
package silu_pkg;

    localparam int DATA_W       = 16;
    localparam int FRAC_BITS    = 12;
    localparam int SIG_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(SIG_SEGMENTS);
    localparam int FR_W         = DATA_W - IDX_W;
    localparam int TAB_W        = FRAC_BITS + 1;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int NSTAGE       = 6;
    localparam int MUL1_W       = DATA_W + TAB_W + 1;
    localparam int ACC_W        = DATA_W + 2;
    localparam int MUL2_W       = 2 * ACC_W;
    localparam int SAT_W        = MUL2_W - FRAC_BITS;

    typedef logic [TAB_W-1:0] sig_t;

    // sigmoid at x = -8.0 .. +8.0 in steps of 0.25, rounded to Q.12
    localparam sig_t SIG_TAB [0:SIG_SEGMENTS] = '{
        13'd1,    13'd2,    13'd2,    13'd3,    13'd4,    13'd5,    13'd6,    13'd8,
        13'd10,   13'd13,   13'd17,   13'd21,   13'd27,   13'd35,   13'd45,   13'd58,
        13'd74,   13'd94,   13'd120,  13'd153,  13'd194,  13'd246,  13'd311,  13'd391,
        13'd488,  13'd606,  13'd747,  13'd912,  13'd1102, 13'd1314, 13'd1546, 13'd1793,
        13'd2048, 13'd2303, 13'd2550, 13'd2782, 13'd2994, 13'd3184, 13'd3349, 13'd3490,
        13'd3608, 13'd3705, 13'd3785, 13'd3850, 13'd3902, 13'd3943, 13'd3976, 13'd4002,
        13'd4022, 13'd4038, 13'd4051, 13'd4061, 13'd4069, 13'd4075, 13'd4079, 13'd4083,
        13'd4086, 13'd4088, 13'd4090, 13'd4091, 13'd4092, 13'd4093, 13'd4094, 13'd4094,
        13'd4095
    };

    typedef enum logic {
        FUNC_FWD  = 1'b0,
        FUNC_GRAD = 1'b1
    } func_e_t;

    typedef struct packed {
        func_e_t                   func;
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  dy;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic ld_read;
        logic ld_interp;
    } lut_en_t;

    function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] max_v;
        logic signed [SAT_W-1:0] min_v;
        max_v = SAT_W'((1 << (DATA_W - 1)) - 1);
        min_v = -max_v - SAT_W'(1);
        if (v > max_v)
        begin
            sat_out = DATA_W'(max_v);
        end
        else if (v < min_v)
        begin
            sat_out = DATA_W'(min_v);
        end
        else
        begin
            sat_out = v[DATA_W-1:0];
        end
    endfunction

endpackage

// ----- src/silu_activation_unit.sv -----
// ============================================================================
// silu_activation_unit: SiLU forward and gradient, Q4.12
// Streaming elementwise SiLU / SiLU-gradient with a piecewise-linear sigmoid.
// ============================================================================
// Usage
//   Slave side takes one request per element: tdata = {grad_in, x_in},
//   tuser = func (0 forward, 1 gradient), tlast marks the end of an array.
//   Master side returns one request per element: tdata = result (saturated
//   Q4.12), tlast copied from the input element.
//   With no stall, a request passes the register stages in order and is
//   then shown on the master side. Throughput is one element per cycle
//   while the master side is ready: six register stages (table read,
//   interpolation, first multipliers, rounding, second multiplier,
//   saturation/output), each with its own valid bit.
//   A stage accepts new data when it is empty or its successor moves, so
//   bubbles are squeezed out when the receiver stalls; with the pipeline
//   full, tready on the slave side follows tready on the master side.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
// ============================================================================
module silu_activation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] x_in, [31:16] grad_in
    input  logic        s_axis_tuser,   // [0] func
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] result
    output logic        m_axis_tlast
);

    localparam int NS = silu_pkg::NSTAGE;
    localparam int DW = silu_pkg::DATA_W;
    localparam int FB = silu_pkg::FRAC_BITS;
    localparam int M1 = silu_pkg::MUL1_W;
    localparam int AW = silu_pkg::ACC_W;
    localparam int M2 = silu_pkg::MUL2_W;
    localparam int SW = silu_pkg::SAT_W;

    logic [NS-1:0]       vld_reg;
    logic [NS-1:0]       vld_next;
    logic [NS:0]         rdy;

    silu_pkg::item_t     item_in;
    silu_pkg::item_t     item_reg [0:NS-1];

    silu_pkg::lut_en_t   lut_en;
    silu_pkg::sig_t      s_val;

    logic signed [M1-1:0] mula_reg;
    logic signed [M1-1:0] mula_next;
    logic signed [M1-1:0] mulb_reg;
    logic signed [M1-1:0] mulb_next;

    logic signed [M1:0]   a_sum;
    logic signed [M1:0]   c_sum;
    logic signed [AW-1:0] a_reg;
    logic signed [AW-1:0] a_next;
    logic signed [AW-1:0] c_reg;
    logic signed [AW-1:0] c_next;
    logic signed [DW-1:0] fwd_reg;
    logic signed [DW-1:0] fwd_next;

    logic signed [M2-1:0] prod_reg;
    logic signed [M2-1:0] prod_next;
    logic signed [DW-1:0] fwd2_reg;

    logic signed [M2:0]   p_sum;
    logic signed [DW-1:0] res_reg;
    logic signed [DW-1:0] res_next;

    logic signed [DW-1:0]  mul_lhs;
    logic signed [FB+1:0]  s_sgn;
    logic signed [FB+1:0]  s_cmp;

    // ---------------------------------------------------------------- control
    always_comb
    begin
        rdy[NS] = m_axis_tready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_next = {vld_reg[NS-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_axis_tready = rdy[0];

    always_comb
    begin
        item_in.func = silu_pkg::func_e_t'(s_axis_tuser);
        item_in.x    = s_axis_tdata[DW-1:0];
        item_in.dy   = s_axis_tdata[2*DW-1:DW];
        item_in.last = s_axis_tlast;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (rdy[k])
            begin
                item_reg[k] <= (k == 0) ? item_in : item_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // ------------------------------------------------------- stages 0 and 1
    assign lut_en.ld_read   = rdy[0];
    assign lut_en.ld_interp = rdy[1];

    silu_sigmoid u_sigmoid (
        .clk (clk),
        .en  (lut_en),
        .x   (item_in.x),
        .s   (s_val)
    );

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        s_sgn   = $signed({1'b0, s_val});
        s_cmp   = $signed((FB+2)'(silu_pkg::ONE)) - s_sgn;
        mul_lhs = (item_reg[1].func == silu_pkg::FUNC_GRAD) ? item_reg[1].dy : item_reg[1].x;
        mula_next = M1'(mul_lhs * s_sgn);
        mulb_next = M1'(item_reg[1].x * s_cmp);
    end

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        a_sum    = (M1+1)'(mula_reg) + $signed((M1+1)'(1 << (FB - 1)));
        c_sum    = (M1+1)'(mulb_reg) + $signed((M1+1)'(1 << (FB - 1)));
        a_next   = a_sum[FB +: AW];
        c_next   = c_sum[FB +: AW] + $signed(AW'(silu_pkg::ONE));
        fwd_next = silu_pkg::sat_out(SW'(a_next));
    end

    // ---------------------------------------------------------------- stage 4
    assign prod_next = M2'(a_reg * c_reg);

    // ---------------------------------------------------------------- stage 5
    always_comb
    begin
        p_sum = (M2+1)'(prod_reg) + $signed((M2+1)'(1 << (FB - 1)));
        if (item_reg[4].func == silu_pkg::FUNC_GRAD)
        begin
            res_next = silu_pkg::sat_out(p_sum[FB +: SW]);
        end
        else
        begin
            res_next = fwd2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            mula_reg <= mula_next;
            mulb_reg <= mulb_next;
        end
        if (rdy[3])
        begin
            a_reg   <= a_next;
            c_reg   <= c_next;
            fwd_reg <= fwd_next;
        end
        if (rdy[4])
        begin
            prod_reg <= prod_next;
            fwd2_reg <= fwd_reg;
        end
        if (rdy[5])
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = res_reg;
    assign m_axis_tlast  = item_reg[NS-1].last;

    function automatic silu_pkg::sig_t TAB_W_ONE();
        TAB_W_ONE = silu_pkg::TAB_W'(silu_pkg::ONE);
    endfunction

    // ------------------------------------------------------------- assertions
    // a ready receiver always lets the whole pipeline move
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("slave side stalled while master side is ready");

    a_sigmoid_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (s_val < TAB_W_ONE()))
        else $error("interpolated sigmoid reached one");

    a_fwd_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && (item_reg[NS-1].func == silu_pkg::FUNC_FWD)
         && !item_reg[NS-1].x[DW-1]) |-> !res_reg[DW-1])
        else $error("forward result negative for non-negative input");

    a_grad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && (item_reg[NS-1].func == silu_pkg::FUNC_GRAD)
         && (item_reg[NS-1].dy == '0)) |-> (res_reg == '0))
        else $error("zero upstream gradient gave a non-zero result");

endmodule

// ----- src/silu_sigmoid.sv -----
// ============================================================================
// silu_sigmoid: two-stage piecewise-linear sigmoid
// Stage one reads the segment base and step from the table, stage two
// interpolates with the fractional position inside the segment.
// ============================================================================
module silu_sigmoid (
    input  logic                                  clk,
    input  silu_pkg::lut_en_t                     en,
    input  logic signed [silu_pkg::DATA_W-1:0]    x,
    output silu_pkg::sig_t                        s
);

    logic [silu_pkg::DATA_W-1:0] u;
    logic [silu_pkg::IDX_W-1:0]  idx;
    logic [silu_pkg::IDX_W:0]    idx_hi;

    silu_pkg::sig_t              lo_reg;
    silu_pkg::sig_t              lo_next;
    silu_pkg::sig_t              d_reg;
    silu_pkg::sig_t              d_next;
    logic [silu_pkg::FR_W-1:0]   fr_reg;
    logic [silu_pkg::FR_W-1:0]   fr_next;
    silu_pkg::sig_t              s_reg;
    silu_pkg::sig_t              s_next;

    logic [silu_pkg::TAB_W+silu_pkg::FR_W:0] interp;

    // offset binary: flip the sign bit
    assign u      = {~x[silu_pkg::DATA_W-1], x[silu_pkg::DATA_W-2:0]};
    assign idx    = u[silu_pkg::DATA_W-1 -: silu_pkg::IDX_W];
    assign idx_hi = {1'b0, idx} + (silu_pkg::IDX_W+1)'(1);

    always_comb
    begin
        lo_next = silu_pkg::SIG_TAB[idx];
        // table is monotone, so the step is never negative
        d_next  = silu_pkg::SIG_TAB[idx_hi] - silu_pkg::SIG_TAB[idx];
        fr_next = u[silu_pkg::FR_W-1:0];
    end

    always_comb
    begin
        interp = (silu_pkg::TAB_W+silu_pkg::FR_W+1)'(d_reg * fr_reg)
               + (silu_pkg::TAB_W+silu_pkg::FR_W+1)'(1 << (silu_pkg::FR_W - 1));
        s_next = lo_reg + interp[silu_pkg::FR_W +: silu_pkg::TAB_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_read)
        begin
            lo_reg <= lo_next;
            d_reg  <= d_next;
            fr_reg <= fr_next;
        end
        if (en.ld_interp)
        begin
            s_reg <= s_next;
        end
    end

    assign s = s_reg;

endmodule
